@@ hw/rtl/swmmm_pkg.sv @@
// swmmm_pkg: constants, types and sequencer states of the sliding window statistics block
// used by the top level, the divider and the port checker; no dependencies

package swmmm_pkg;

   localparam int WINDOW_DEPTH = 64;
   localparam int SAMPLE_BITS  = 16;
   localparam int AXES         = 3;
   localparam int LEN_BITS     = 7;
   localparam int LEN_RESET    = 64;
   localparam int SLOT_BITS    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int AXIS_BITS    = $clog2(AXES);
   // a full window sum of signed samples
   localparam int SUM_BITS     = SAMPLE_BITS + $clog2(WINDOW_DEPTH + 1);
   localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [SUM_BITS-1:0]    sum_type;
   typedef logic [LEN_BITS-1:0]           len_type;
   typedef logic [SLOT_BITS-1:0]          slot_type;
   typedef logic [AXIS_BITS-1:0]          axis_type;
   typedef logic [AXES-1:0][SAMPLE_BITS-1:0] triple_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV_LAUNCH,
      ST_DIV_WAIT,
      ST_DONE
   } state_type;

endpackage

@@ hw/rtl/swmmm_div.sv @@
// swmmm_div: bit-serial restoring divider, signed window sum by window length
// depends on swmmm_pkg; quotient truncates toward zero

module swmmm_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  swmmm_pkg::sum_type dividend,
   input  swmmm_pkg::len_type divisor,
   output logic               done,
   output swmmm_pkg::sample_type quotient
);
   import swmmm_pkg::*;

   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                    done_ff, done_in;
   logic                    neg_ff, neg_in;
   logic [SUM_BITS-1:0]     dvd_ff, dvd_in;
   len_type                 rem_ff, rem_in;
   len_type                 dvs_ff, dvs_in;
   logic [LEN_BITS:0]       trial;
   logic [SUM_BITS-1:0]     signed_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, dvd_ff[SUM_BITS-1]};
      if (start) begin
         neg_in = dividend[SUM_BITS-1];
         dvd_in = dividend[SUM_BITS-1] ? (-dividend) : dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = DIV_CNT_BITS'(SUM_BITS);
      end else if (cnt_ff != '0) begin
         // one quotient bit per cycle
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = LEN_BITS'(trial - {1'b0, dvs_ff});
            dvd_in = {dvd_ff[SUM_BITS-2:0], 1'b1};
         end else begin
            rem_in = trial[LEN_BITS-1:0];
            dvd_in = {dvd_ff[SUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   assign signed_q = neg_ff ? (-dvd_ff) : dvd_ff;
   assign quotient = signed_q[SAMPLE_BITS-1:0];
   assign done     = done_ff;

endmodule

@@ hw/rtl/sliding_window_mean_min_max.sv @@
// sliding_window_mean_min_max: top level, sample store, scan sequencer and output register
// depends on swmmm_pkg and swmmm_div

// Takes one three-axis sample per word on the req channel and keeps the newest
// WINDOW_DEPTH samples in a circular store. Once window_length samples have
// arrived since reset or the last csr write, every sample gives one rsp word:
// the sample itself plus the per-axis mean (truncated toward zero), peak and
// trough over the newest window_length samples, the current one included.
// A window_length of 0 acts as 1 and one above WINDOW_DEPTH as WINDOW_DEPTH.
// A csr write restarts the fill; the stored samples and write slot are kept.
// A sample that does not complete the fill is taken and gives no word. A
// sample that yields a result keeps req_ready low while the sequencer scans
// the newest L samples, L the effective window length, over the single read
// port of the sample store (one entry per cycle) and then runs the shared
// bit-serial divider, from a launch state, once for each axis.
// A finished word sits in the rsp register, so req is taken again while it
// waits for rsp_ready.

module sliding_window_mean_min_max (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  swmmm_pkg::sample_type req_sample_x,
   input  swmmm_pkg::sample_type req_sample_y,
   input  swmmm_pkg::sample_type req_sample_z,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output swmmm_pkg::sample_type rsp_echo_x,
   output swmmm_pkg::sample_type rsp_echo_y,
   output swmmm_pkg::sample_type rsp_echo_z,
   output swmmm_pkg::sample_type rsp_mean_x,
   output swmmm_pkg::sample_type rsp_mean_y,
   output swmmm_pkg::sample_type rsp_mean_z,
   output swmmm_pkg::sample_type rsp_peak_x,
   output swmmm_pkg::sample_type rsp_trough_x,
   output swmmm_pkg::sample_type rsp_peak_y,
   output swmmm_pkg::sample_type rsp_trough_y,
   output swmmm_pkg::sample_type rsp_peak_z,
   output swmmm_pkg::sample_type rsp_trough_z,
   input  logic                  csr_wr_en,
   input  swmmm_pkg::len_type    csr_wr_data
);
   import swmmm_pkg::*;

   // sequencer and bookkeeping
   state_type  state_ff, state_in;
   slot_type   ws_ff, ws_in;           // next slot to write
   len_type    fill_ff, fill_in;       // samples since last clear, saturating
   len_type    len_ff, len_in;         // window_length as written
   slot_type   rd_ptr_ff, rd_ptr_in;   // scan read address, walks backward
   len_type    cnt_ff, cnt_in;         // scan step
   axis_type   axis_ff, axis_in;       // axis being divided
   logic       rsp_valid_ff, rsp_valid_in;

   // working data
   triple_type cur_ff, cur_in;
   sum_type    sum_ff [AXES];
   sum_type    sum_in [AXES];
   triple_type peak_ff, peak_in;
   triple_type trough_ff, trough_in;
   triple_type mean_ff, mean_in;

   // rsp register
   triple_type out_echo_ff, out_echo_in;
   triple_type out_mean_ff, out_mean_in;
   triple_type out_peak_ff, out_peak_in;
   triple_type out_trough_ff, out_trough_in;

   // sample store
   triple_type mem [WINDOW_DEPTH];
   triple_type rd_data_ff;
   triple_type req_word;
   logic       mem_we;

   len_type    eff_len;
   len_type    fill_next;
   logic       div_start;
   logic       div_done;
   sample_type div_quot;

   assign req_word = {req_sample_z, req_sample_y, req_sample_x};
   assign req_ready = (state_ff == ST_IDLE);
   assign mem_we    = req_valid && req_ready;

   // zero acts as one, anything past the store depth as the depth
   always_comb begin
      if (len_ff == '0) begin
         eff_len = LEN_BITS'(1);
      end else if (len_ff > LEN_BITS'(WINDOW_DEPTH)) begin
         eff_len = LEN_BITS'(WINDOW_DEPTH);
      end else begin
         eff_len = len_ff;
      end
   end

   assign fill_next = (fill_ff < eff_len) ? (fill_ff + 1'b1) : fill_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[ws_ff] <= req_word;
      end
      rd_data_ff <= mem[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ws_ff        <= '0;
         fill_ff      <= '0;
         len_ff       <= LEN_BITS'(LEN_RESET);
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         axis_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         ws_ff        <= ws_in;
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         axis_ff      <= axis_in;
      end
      rd_ptr_ff     <= rd_ptr_in;
      cur_ff        <= cur_in;
      sum_ff        <= sum_in;
      peak_ff       <= peak_in;
      trough_ff     <= trough_in;
      mean_ff       <= mean_in;
      out_echo_ff   <= out_echo_in;
      out_mean_ff   <= out_mean_in;
      out_peak_ff   <= out_peak_in;
      out_trough_ff <= out_trough_in;
   end

   always_comb begin
      state_in      = state_ff;
      ws_in         = ws_ff;
      fill_in       = fill_ff;
      len_in        = len_ff;
      rd_ptr_in     = rd_ptr_ff;
      cnt_in        = cnt_ff;
      axis_in       = axis_ff;
      cur_in        = cur_ff;
      sum_in        = sum_ff;
      peak_in       = peak_ff;
      trough_in     = trough_ff;
      mean_in       = mean_ff;
      out_echo_in   = out_echo_ff;
      out_mean_in   = out_mean_ff;
      out_peak_in   = out_peak_ff;
      out_trough_in = out_trough_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      div_start     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (mem_we) begin
               // the store write happens in the memory block
               cur_in    = req_word;
               ws_in     = (ws_ff == SLOT_BITS'(WINDOW_DEPTH - 1)) ? '0 : ws_ff + 1'b1;
               fill_in   = fill_next;
               rd_ptr_in = ws_ff;
               cnt_in    = '0;
               if (fill_next >= eff_len) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // read issued at step k lands at step k + 1
            rd_ptr_in = (rd_ptr_ff == '0) ? SLOT_BITS'(WINDOW_DEPTH - 1) : rd_ptr_ff - 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff != '0) begin
               for (int i = 0; i < AXES; i++) begin
                  if (cnt_ff == LEN_BITS'(1)) begin
                     sum_in[i]    = SUM_BITS'($signed(rd_data_ff[i]));
                     peak_in[i]   = rd_data_ff[i];
                     trough_in[i] = rd_data_ff[i];
                  end else begin
                     sum_in[i] = sum_ff[i] + SUM_BITS'($signed(rd_data_ff[i]));
                     if ($signed(rd_data_ff[i]) > $signed(peak_ff[i])) begin
                        peak_in[i] = rd_data_ff[i];
                     end
                     if ($signed(rd_data_ff[i]) < $signed(trough_ff[i])) begin
                        trough_in[i] = rd_data_ff[i];
                     end
                  end
               end
               if (cnt_ff == eff_len) begin
                  axis_in  = '0;
                  state_in = ST_DIV_LAUNCH;
               end
            end
         end
         ST_DIV_LAUNCH: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               mean_in[axis_ff] = div_quot;
               if (axis_ff == AXIS_BITS'(AXES - 1)) begin
                  state_in = ST_DONE;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = ST_DIV_LAUNCH;
               end
            end
         end
         ST_DONE: begin
            // hand over once the rsp register is free
            if (!rsp_valid_ff || rsp_ready) begin
               out_echo_in   = cur_ff;
               out_mean_in   = mean_ff;
               out_peak_in   = peak_ff;
               out_trough_in = trough_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // the user must issue csr writes only while idle; the block does not enforce it
      if (csr_wr_en) begin
         len_in  = csr_wr_data;
         fill_in = '0;
      end
   end

   swmmm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff[axis_ff]),
      .divisor  (eff_len),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_echo_x   = out_echo_ff[0];
   assign rsp_echo_y   = out_echo_ff[1];
   assign rsp_echo_z   = out_echo_ff[2];
   assign rsp_mean_x   = out_mean_ff[0];
   assign rsp_mean_y   = out_mean_ff[1];
   assign rsp_mean_z   = out_mean_ff[2];
   assign rsp_peak_x   = out_peak_ff[0];
   assign rsp_trough_x = out_trough_ff[0];
   assign rsp_peak_y   = out_peak_ff[1];
   assign rsp_trough_y = out_trough_ff[1];
   assign rsp_peak_z   = out_peak_ff[2];
   assign rsp_trough_z = out_trough_ff[2];

endmodule

@@ hw/rtl/swmmm_checker.sv @@
// swmmm_checker: port-level checks of the sliding window statistics block
// depends on swmmm_pkg; bound to sliding_window_mean_min_max below

module swmmm_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input swmmm_pkg::sample_type rsp_echo_x,
   input swmmm_pkg::sample_type rsp_echo_y,
   input swmmm_pkg::sample_type rsp_echo_z,
   input swmmm_pkg::sample_type rsp_mean_x,
   input swmmm_pkg::sample_type rsp_mean_y,
   input swmmm_pkg::sample_type rsp_mean_z,
   input swmmm_pkg::sample_type rsp_peak_x,
   input swmmm_pkg::sample_type rsp_trough_x,
   input swmmm_pkg::sample_type rsp_peak_y,
   input swmmm_pkg::sample_type rsp_trough_y,
   input swmmm_pkg::sample_type rsp_peak_z,
   input swmmm_pkg::sample_type rsp_trough_z
);
   import swmmm_pkg::*;

   // no word right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a stalled word stays valid and keeps its x mean and z peak
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mean_x) && $stable(rsp_peak_z))
      else $error("rsp word changed while stalled");

   // the mean lies between trough and peak
   a_mean_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mean_x <= rsp_peak_x && rsp_mean_x >= rsp_trough_x
                 && rsp_mean_y <= rsp_peak_y && rsp_mean_y >= rsp_trough_y
                 && rsp_mean_z <= rsp_peak_z && rsp_mean_z >= rsp_trough_z)
      else $error("mean outside window range");

   // the current sample is part of its own window
   a_echo_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_echo_x <= rsp_peak_x && rsp_echo_x >= rsp_trough_x
                 && rsp_echo_y <= rsp_peak_y && rsp_echo_y >= rsp_trough_y
                 && rsp_echo_z <= rsp_peak_z && rsp_echo_z >= rsp_trough_z)
      else $error("echoed sample outside window range");

endmodule

bind sliding_window_mean_min_max swmmm_checker u_swmmm_checker (.*);
